[rtl/assert_macros.svh]
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/hkrb_pkg.sv]
`default_nettype none

package hkrb_pkg;

  // Input function codes.
  typedef enum logic [1:0] {
    FUNC_PRESS       = 2'd0,
    FUNC_RELEASE     = 2'd1,
    FUNC_WRITE       = 2'd2,
    FUNC_RELEASE_ALL = 2'd3
  } hkrb_func_t;

  // Operation that the datapath performs in a given cycle.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_PRESS,
    OP_RELEASE,
    OP_CLEAR
  } hkrb_op_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRESS,
    ST_WRITE_PRESS,
    ST_RELEASE,
    ST_CLEAR
  } hkrb_state_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic     load;
    hkrb_op_t op;
    logic     last;
  } hkrb_cmd_t;

  localparam logic [7:0] RAW_BASE   = 8'd136;
  localparam logic [7:0] MOD_BASE   = 8'd128;
  localparam logic [7:0] SHIFT_MARK = 8'h80;
  localparam logic [7:0] LEFT_SHIFT = 8'h02;
  localparam logic [7:0] USAGE_MASK = 8'h7F;
  localparam logic [7:0] NO_USAGE   = 8'h00;

  // US layout ASCII to usage table; bit 7 marks characters that need left shift.
  localparam logic [7:0] US_MAP [128] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
    8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
    8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
    8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
    8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
    8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
    8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
    8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
    8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
    8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
    8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
    8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
  };

endpackage

`default_nettype wire

[rtl/hkrb_ctrl.sv]
`default_nettype none

module hkrb_ctrl import hkrb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_func,
  output logic            busy,
  output hkrb_cmd_t       cmd
);

  hkrb_state_t state_r;
  hkrb_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    busy      = 1'b1;
    cmd.load  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.last  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          case (hkrb_func_t'(in_func))
            FUNC_PRESS:       state_nxt = ST_PRESS;
            FUNC_RELEASE:     state_nxt = ST_RELEASE;
            FUNC_WRITE:       state_nxt = ST_WRITE_PRESS;
            FUNC_RELEASE_ALL: state_nxt = ST_CLEAR;
            default:          state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PRESS: begin
        cmd.op    = OP_PRESS;
        state_nxt = ST_IDLE;
      end
      // First half of a write; the release follows with the final result.
      ST_WRITE_PRESS: begin
        cmd.op    = OP_PRESS;
        cmd.last  = 1'b0;
        state_nxt = ST_RELEASE;
      end
      ST_RELEASE: begin
        cmd.op    = OP_RELEASE;
        state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd.op    = OP_CLEAR;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/hkrb_dp.sv]
`default_nettype none

module hkrb_dp import hkrb_pkg::*; #(
  parameter int SLOT_COUNT = 6
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire hkrb_cmd_t  cmd,
  input  wire logic [7:0] in_key,
  output logic            out_strobe,
  output logic [7:0]      out_modifiers,
  output logic [7:0]      out_slot_zero,
  output logic [7:0]      out_slot_one,
  output logic [7:0]      out_slot_two,
  output logic [7:0]      out_slot_three,
  output logic [7:0]      out_slot_four,
  output logic [7:0]      out_slot_five,
  output logic            out_report_sent,
  output logic            out_ok,
  output logic            out_error_flag,
  output logic            out_last
);

  // Report state.
  logic [7:0] key_r;
  logic [7:0] mod_r;
  logic [7:0] mod_nxt;
  logic [7:0] slots_r   [SLOT_COUNT];
  logic [7:0] slots_nxt [SLOT_COUNT];
  logic       err_r;
  logic       err_nxt;

  // Decoded key.
  logic       is_raw;
  logic       is_mod;
  logic       is_ascii;
  logic [7:0] map_code;
  logic       unmapped;
  logic [7:0] mod_mask;
  logic [7:0] usage;
  logic       present;
  logic       placed;
  logic       act_ok;

  // Result registers.
  logic       strobe_r;
  logic [7:0] res_mod_r;
  logic [7:0] res_slot_r [6];
  logic [7:0] view       [6];
  logic       res_ok_r;
  logic       res_err_r;
  logic       res_last_r;

  // Key capture at acceptance.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_key;
    end
  end

  // Key decode: raw usage, modifier bit or table lookup.
  always_comb begin
    is_raw   = (key_r >= RAW_BASE);
    is_mod   = (key_r >= MOD_BASE) && !is_raw;
    is_ascii = !key_r[7];
    map_code = US_MAP[key_r[6:0]];
    unmapped = is_ascii && (map_code == NO_USAGE);
    mod_mask = is_mod ? (8'h01 << key_r[2:0]) : 8'h00;
    if (is_ascii && ((map_code & SHIFT_MARK) != NO_USAGE)) begin
      mod_mask = mod_mask | LEFT_SHIFT;
    end
    if (is_raw) begin
      usage = key_r - RAW_BASE;
    end else if (is_ascii) begin
      usage = map_code & USAGE_MASK;
    end else begin
      usage = NO_USAGE;
    end
  end

  // Report update for the commanded operation.
  always_comb begin
    mod_nxt = mod_r;
    err_nxt = err_r;
    act_ok  = 1'b0;
    present = 1'b0;
    placed  = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slots_nxt[i] = slots_r[i];
      if (slots_r[i] == usage) begin
        present = 1'b1;
      end
    end
    case (cmd.op)
      OP_PRESS: begin
        if (unmapped) begin
          err_nxt = 1'b1;
        end else begin
          mod_nxt = mod_r | mod_mask;
          if (present) begin
            act_ok = 1'b1;
          end else begin
            // Fill the first empty slot.
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (!placed && (slots_r[i] == NO_USAGE)) begin
                slots_nxt[i] = usage;
                placed       = 1'b1;
              end
            end
            act_ok = placed;
            if (!placed) begin
              err_nxt = 1'b1;
            end
          end
        end
      end
      OP_RELEASE: begin
        if (!unmapped) begin
          act_ok  = 1'b1;
          mod_nxt = mod_r & ~mod_mask;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if ((usage != NO_USAGE) && (slots_r[i] == usage)) begin
              slots_nxt[i] = NO_USAGE;
            end
          end
        end
      end
      OP_CLEAR: begin
        act_ok  = 1'b1;
        mod_nxt = 8'h00;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          slots_nxt[i] = NO_USAGE;
        end
      end
      default: begin
        act_ok = 1'b0;
      end
    endcase
  end

  // Report state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= 8'h00;
      err_r <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots_r[i] <= NO_USAGE;
      end
    end else begin
      mod_r <= mod_nxt;
      err_r <= err_nxt;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots_r[i] <= slots_nxt[i];
      end
    end
  end

  // The six report slots; slots past the configured count read as empty.
  for (genvar g = 0; g < 6; g++) begin : g_view
    if (g < SLOT_COUNT) begin : g_live
      assign view[g] = slots_nxt[g];
    end else begin : g_empty
      assign view[g] = NO_USAGE;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= (cmd.op != OP_NONE);
    end
  end

  // Result payload, captured with the state it reports.
  always_ff @(posedge clk) begin
    if (cmd.op != OP_NONE) begin
      res_mod_r  <= mod_nxt;
      res_ok_r   <= act_ok;
      res_err_r  <= err_nxt;
      res_last_r <= cmd.last;
      for (int j = 0; j < 6; j++) begin
        res_slot_r[j] <= view[j];
      end
    end
  end

  assign out_strobe      = strobe_r;
  assign out_modifiers   = res_mod_r;
  assign out_slot_zero   = res_slot_r[0];
  assign out_slot_one    = res_slot_r[1];
  assign out_slot_two    = res_slot_r[2];
  assign out_slot_three  = res_slot_r[3];
  assign out_slot_four   = res_slot_r[4];
  assign out_slot_five   = res_slot_r[5];
  assign out_report_sent = res_ok_r;
  assign out_ok          = res_ok_r;
  assign out_error_flag  = res_err_r;
  assign out_last        = res_last_r;

endmodule

`default_nettype wire

[rtl/hid_keyboard_report_builder.sv]
// Channel   | Handshake                 | Payload
// ----------+---------------------------+------------------------------------------
// input     | start, busy               | in_func, in_key
// result    | out_strobe (one cycle)    | out_modifiers, out_slot_*, out_report_sent,
//           |                           | out_ok, out_error_flag, out_last
//
// Press, release and release-all give one result strobe each; write gives two: the
// press result with out_last low, then the release result. The controller walks one
// operation per cycle through the shared report update logic, and busy is low again
// in the cycle the final result is shown.
// Reset (rst_n low, synchronous) empties the report and clears the error flag.
// The receiver cannot stall; each result is shown for one cycle only.
`default_nettype none

`include "assert_macros.svh"

module hid_keyboard_report_builder import hkrb_pkg::*; #(
  parameter int SLOT_COUNT = 6
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_func,
  input  wire logic [7:0] in_key,
  output logic            out_strobe,
  output logic [7:0]      out_modifiers,
  output logic [7:0]      out_slot_zero,
  output logic [7:0]      out_slot_one,
  output logic [7:0]      out_slot_two,
  output logic [7:0]      out_slot_three,
  output logic [7:0]      out_slot_four,
  output logic [7:0]      out_slot_five,
  output logic            out_report_sent,
  output logic            out_ok,
  output logic            out_error_flag,
  output logic            out_last
);

  hkrb_cmd_t cmd;
  logic      accept;

  assign accept = start && !busy;

  // Sequencer for the operations of one transaction.
  hkrb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .busy    (busy),
    .cmd     (cmd)
  );

  // Report state, update logic and result registers.
  hkrb_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_key          (in_key),
    .out_strobe      (out_strobe),
    .out_modifiers   (out_modifiers),
    .out_slot_zero   (out_slot_zero),
    .out_slot_one    (out_slot_one),
    .out_slot_two    (out_slot_two),
    .out_slot_three  (out_slot_three),
    .out_slot_four   (out_slot_four),
    .out_slot_five   (out_slot_five),
    .out_report_sent (out_report_sent),
    .out_ok          (out_ok),
    .out_error_flag  (out_error_flag),
    .out_last        (out_last)
  );

  // A non-final result is always followed directly by the final one.
  `ASSERT_NEXT(a_write_pair, clk, rst_n, out_strobe && !out_last, out_strobe && out_last)
  // No result appears in the cycle right after a transaction is accepted.
  `ASSERT_NEXT(a_no_early_result, clk, rst_n, accept, !out_strobe)
  // The final result coincides with the controller being free again.
  `ASSERT_SAME(a_last_frees, clk, rst_n, out_strobe && out_last, !busy)

endmodule

`default_nettype wire

[tb/hid_keyboard_report_builder_tb.sv]
`timescale 1ns / 100ps

module hid_keyboard_report_builder_tb import hkrb_pkg::*; ();

  localparam int NUM_SLOTS = 6;
  localparam int RANDOM_COMMANDS = 1800;
  localparam int REPORT_LIMIT = 10;

  // One keyboard report as shown on the result ports.
  typedef struct packed {
    logic [7:0]                modifiers;
    logic [NUM_SLOTS-1:0][7:0] slots;
    logic                      sent;
    logic                      ok;
    logic                      error_flag;
    logic                      last;
  } keyboard_report_t;

  // Tracks the keyboard report and holds the reports the block still owes.
  class keyboard_report_tracker;
    logic [7:0]                mod_state;
    logic [NUM_SLOTS-1:0][7:0] slot_state;
    logic                      error_state;
    keyboard_report_t          expected_reports[$];
    int                        failures;

    function void clear_state();
      mod_state = 8'h00;
      slot_state = '0;
      error_state = 1'b0;
      failures = 0;
      expected_reports.delete();
    endfunction

    function keyboard_report_t snapshot(logic sent, logic ok, logic last);
      keyboard_report_t r;
      r.modifiers = mod_state;
      r.slots = slot_state;
      r.sent = sent;
      r.ok = ok;
      r.error_flag = error_state;
      r.last = last;
      return r;
    endfunction

    // Press: add the usage to the first free slot unless it is already held.
    function logic press_key(logic [7:0] key);
      logic [7:0] usage;
      logic       present;
      int         free_idx;
      if (key >= RAW_BASE) begin
        usage = key - RAW_BASE;
      end else if (key >= MOD_BASE) begin
        mod_state[key[2:0]] = 1'b1;
        usage = NO_USAGE;
      end else begin
        usage = US_MAP[key[6:0]];
        if (usage == NO_USAGE) begin
          error_state = 1'b1;
          return 1'b0;
        end
        if ((usage & SHIFT_MARK) != 8'h00) begin
          mod_state = mod_state | LEFT_SHIFT;
          usage = usage & USAGE_MASK;
        end
      end
      present = 1'b0;
      free_idx = -1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_state[i] == usage) present = 1'b1;
        if (slot_state[i] == NO_USAGE && free_idx < 0) free_idx = i;
      end
      if (!present) begin
        if (free_idx < 0) begin
          error_state = 1'b1;
          return 1'b0;
        end
        slot_state[free_idx] = usage;
      end
      return 1'b1;
    endfunction

    // Release: clear every slot holding the usage; usage zero clears nothing.
    function logic release_key(logic [7:0] key);
      logic [7:0] usage;
      if (key >= RAW_BASE) begin
        usage = key - RAW_BASE;
      end else if (key >= MOD_BASE) begin
        mod_state[key[2:0]] = 1'b0;
        usage = NO_USAGE;
      end else begin
        usage = US_MAP[key[6:0]];
        if (usage == NO_USAGE) return 1'b0;
        if ((usage & SHIFT_MARK) != 8'h00) begin
          mod_state = mod_state & ~LEFT_SHIFT;
          usage = usage & USAGE_MASK;
        end
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (usage != NO_USAGE && slot_state[i] == usage) slot_state[i] = NO_USAGE;
      end
      return 1'b1;
    endfunction

    // Work out the reports that one accepted transaction produces.
    function void note_command(hkrb_func_t func, logic [7:0] key);
      logic r;
      case (func)
        FUNC_PRESS: begin
          r = press_key(key);
          expected_reports.push_back(snapshot(r, r, 1'b1));
        end
        FUNC_RELEASE: begin
          r = release_key(key);
          expected_reports.push_back(snapshot(r, r, 1'b1));
        end
        FUNC_WRITE: begin
          r = press_key(key);
          expected_reports.push_back(snapshot(r, r, 1'b0));
          r = release_key(key);
          expected_reports.push_back(snapshot(r, r, 1'b1));
        end
        default: begin
          mod_state = 8'h00;
          slot_state = '0;
          expected_reports.push_back(snapshot(1'b1, 1'b1, 1'b1));
        end
      endcase
    endfunction

    function string describe(keyboard_report_t r);
      return $sformatf("mod=%02h slots=%02h %02h %02h %02h %02h %02h sent=%b ok=%b err=%b last=%b",
                       r.modifiers, r.slots[0], r.slots[1], r.slots[2], r.slots[3],
                       r.slots[4], r.slots[5], r.sent, r.ok, r.error_flag, r.last);
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    // Compare one shown report with the oldest one owed.
    function void check_report(keyboard_report_t actual);
      keyboard_report_t want;
      logic             bad;
      if (expected_reports.size() == 0) begin
        note_failure($sformatf("%0t: report with none owed: %s", $time, describe(actual)));
        return;
      end
      want = expected_reports.pop_front();
      bad = (want.modifiers !== actual.modifiers) || (want.sent !== actual.sent) ||
            (want.ok !== actual.ok) || (want.error_flag !== actual.error_flag) ||
            (want.last !== actual.last);
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (want.slots[i] !== actual.slots[i]) bad = 1'b1;
      end
      if (bad) begin
        note_failure($sformatf("%0t: report mismatch\n  expected %s\n  actual   %s",
                               $time, describe(want), describe(actual)));
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_func;
  logic [7:0] in_key;
  logic       out_strobe;
  logic [7:0] out_modifiers;
  logic [7:0] out_slot_zero;
  logic [7:0] out_slot_one;
  logic [7:0] out_slot_two;
  logic [7:0] out_slot_three;
  logic [7:0] out_slot_four;
  logic [7:0] out_slot_five;
  logic       out_report_sent;
  logic       out_ok;
  logic       out_error_flag;
  logic       out_last;

  keyboard_report_tracker tracker = new;
  logic [7:0]             key_pool [8];

  hid_keyboard_report_builder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_key         (in_key),
    .out_strobe     (out_strobe),
    .out_modifiers  (out_modifiers),
    .out_slot_zero  (out_slot_zero),
    .out_slot_one   (out_slot_one),
    .out_slot_two   (out_slot_two),
    .out_slot_three (out_slot_three),
    .out_slot_four  (out_slot_four),
    .out_slot_five  (out_slot_five),
    .out_report_sent(out_report_sent),
    .out_ok         (out_ok),
    .out_error_flag (out_error_flag),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watch both channels at the rising edge.
  always @(posedge clk) begin : channel_monitor
    keyboard_report_t seen;
    if (rst_n) begin
      if (out_strobe) begin
        seen.modifiers = out_modifiers;
        seen.slots = {out_slot_five, out_slot_four, out_slot_three,
                      out_slot_two, out_slot_one, out_slot_zero};
        seen.sent = out_report_sent;
        seen.ok = out_ok;
        seen.error_flag = out_error_flag;
        seen.last = out_last;
        tracker.check_report(seen);
      end
      if (start && !busy) tracker.note_command(hkrb_func_t'(in_func), in_key);
    end
  end

  // Present one transaction and hold it until the block takes it.
  task issue_command(hkrb_func_t func, logic [7:0] key);
    start <= 1'b1;
    in_func <= func;
    in_key <= key;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Leave the input channel idle, with junk on the payload.
  task pause(int cycles);
    start <= 1'b0;
    in_func <= 2'($urandom);
    in_key <= 8'($urandom);
    repeat (cycles) @(negedge clk);
  endtask

  // The pool mixes mapped ASCII and raw usages so keys repeat and slots fill.
  function void refresh_pool();
    foreach (key_pool[i]) begin
      key_pool[i] = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(136, 255))
                                                : 8'($urandom_range(32, 126));
    end
  endfunction

  function void pick_command(output hkrb_func_t func, output logic [7:0] key);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) func = FUNC_PRESS;
    else if (sel < 80) func = FUNC_RELEASE;
    else if (sel < 95) func = FUNC_WRITE;
    else func = FUNC_RELEASE_ALL;
    if (func == FUNC_RELEASE_ALL && $urandom_range(0, 1) == 0) refresh_pool();
    case ($urandom_range(0, 9))
      6, 7:    key = 8'($urandom_range(0, 255));
      8:       key = 8'($urandom_range(128, 135));
      9:       key = 8'($urandom_range(0, 127));
      default: key = key_pool[$urandom_range(0, 7)];
    endcase
  endfunction

  initial begin : stimulus
    hkrb_func_t func;
    logic [7:0] key;
    int         issued;
    int         burst_len;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FUNC_PRESS;
    in_key = 8'h00;
    tracker.clear_state();
    refresh_pool();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed transactions: shift handling, modifiers, usage zero, full slots.
    issue_command(FUNC_PRESS, 8'h61);
    issue_command(FUNC_PRESS, 8'h41);
    issue_command(FUNC_PRESS, 8'h00);
    issue_command(FUNC_RELEASE, 8'h00);
    pause(2);
    issue_command(FUNC_PRESS, 8'd128);
    issue_command(FUNC_PRESS, 8'd135);
    issue_command(FUNC_PRESS, 8'd136);
    issue_command(FUNC_PRESS, 8'd255);
    issue_command(FUNC_PRESS, 8'h31);
    issue_command(FUNC_PRESS, 8'h21);
    issue_command(FUNC_PRESS, 8'd137);
    issue_command(FUNC_PRESS, 8'd138);
    issue_command(FUNC_PRESS, 8'd139);
    issue_command(FUNC_PRESS, 8'd140);
    issue_command(FUNC_PRESS, 8'h22);
    issue_command(FUNC_PRESS, 8'd136);
    pause(1);
    issue_command(FUNC_RELEASE, 8'd136);
    issue_command(FUNC_RELEASE, 8'h41);
    issue_command(FUNC_RELEASE, 8'd128);
    issue_command(FUNC_RELEASE, 8'd135);
    issue_command(FUNC_WRITE, 8'h7F);
    issue_command(FUNC_WRITE, 8'h7A);
    issue_command(FUNC_RELEASE_ALL, 8'h00);
    issue_command(FUNC_WRITE, 8'd136);
    issue_command(FUNC_PRESS, 8'h0A);

    // Random traffic in bursts; about a quarter of the bursts run straight on.
    issued = 0;
    while (issued < RANDOM_COMMANDS) begin
      burst_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
      repeat (burst_len) begin
        pick_command(func, key);
        issue_command(func, key);
        issued++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
    end

    // Drain the reports still owed, then watch for stray strobes.
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog in case the block stops taking transactions or stops reporting.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/hkrb_pkg.sv
rtl/hkrb_ctrl.sv
rtl/hkrb_dp.sv
rtl/hid_keyboard_report_builder.sv
tb/hid_keyboard_report_builder_tb.sv
